### hdl/lamport_group_admission_table_defines.svh
// ----------------------------------------------------------------------------
// Lamport group admission table: assertion macros
// Shared assertion helpers that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef LAMPORT_GROUP_ADMISSION_TABLE_DEFINES_SVH
`define LAMPORT_GROUP_ADMISSION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define LGAT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lgat assertion failed");
`define LGAT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("lgat forbidden condition");
`else
`define LGAT_ASSERT(lbl, clk, rstn, prop)
`define LGAT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### hdl/lgat_pkg.sv
// ----------------------------------------------------------------------------
// Lamport group admission table package
// Field widths, operation codes and the cell control word.
// ----------------------------------------------------------------------------
package lgat_pkg;

    localparam int NODE_W   = 4;
    localparam int STAMP_W  = 31;
    localparam int CFG_W    = 5;
    localparam int OP_W     = 2;
    localparam int QLEN_W   = 5;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_RECORD  = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_LEADER  = 2'd2;
    localparam logic [OP_W-1:0] OP_MEMBER  = 2'd3;

    localparam logic [0:0] REG_GUIDES = 1'b0;
    localparam logic [0:0] REG_GROUP  = 1'b1;

    localparam logic [CFG_W-1:0]  MAX_BLOCK = 5'd16;
    localparam logic [QLEN_W-1:0] QLEN_MAX  = 5'd31;

    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic wr;
        logic set;
    } cell_ctl_t;

endpackage

### hdl/lgat_cell.sv
// ----------------------------------------------------------------------------
// Lamport group admission table: request cell
// Holds one node's slot and ranks it against the entries passing the ring.
// ----------------------------------------------------------------------------
module lgat_cell import lgat_pkg::*; #(
    parameter int ID = 0,
    parameter int IW = 4,
    parameter int RW = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctl_t          ctl,
    input  logic               wr_hit,
    input  logic [STAMP_W-1:0] wr_stamp,
    input  logic               prev_act,
    input  logic [STAMP_W-1:0] prev_stamp,
    input  logic [IW-1:0]      prev_id,
    output logic               pass_act,
    output logic [STAMP_W-1:0] pass_stamp,
    output logic [IW-1:0]      pass_id,
    output logic               home_act,
    output logic [STAMP_W-1:0] home_stamp,
    output logic [RW-1:0]      rank
);

    logic               act_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               p_act_reg;
    logic [STAMP_W-1:0] p_stamp_reg;
    logic [IW-1:0]      p_id_reg;
    logic [RW-1:0]      rank_reg;
    logic               ahead;

    assign ahead = p_act_reg && ((p_stamp_reg < stamp_reg) ||
                   ((p_stamp_reg == stamp_reg) && (p_id_reg < IW'(ID))));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else if (ctl.wr && wr_hit) begin
            act_reg <= ctl.set;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr && wr_hit) begin
            stamp_reg <= ctl.set ? wr_stamp : '0;
        end
        if (ctl.load) begin
            p_act_reg   <= act_reg;
            p_stamp_reg <= stamp_reg;
            p_id_reg    <= IW'(ID);
            rank_reg    <= '0;
        end else if (ctl.shift) begin
            p_act_reg   <= prev_act;
            p_stamp_reg <= prev_stamp;
            p_id_reg    <= prev_id;
            if (ctl.count && ahead) begin
                rank_reg <= rank_reg + RW'(1);
            end
        end
    end

    assign pass_act   = p_act_reg;
    assign pass_stamp = p_stamp_reg;
    assign pass_id    = p_id_reg;
    assign home_act   = act_reg;
    assign home_stamp = stamp_reg;
    assign rank       = rank_reg;

endmodule

### hdl/lamport_group_admission_table.sv
// ----------------------------------------------------------------------------
// Lamport group admission table
// Timestamp-ordered request slots with leader and membership queries.
// ----------------------------------------------------------------------------
// Each node owns one cell; the cells form a ring. A record or release word is
// applied in the cycle it is accepted and then answered from the response
// state. A query word loads every cell's entry into the ring and rotates it
// once around, so each cell counts the active entries ranked ahead of its own.
// A pick state then latches the leader's rank, and a search steps block by
// block (at most guides blocks) to locate the leader's block. A granted leader
// query emits group_size output words (one when group_size is zero), any other
// word a single one. The next word is accepted once the last output word sits
// in the output register.
module lamport_group_admission_table
    import lgat_pkg::*;
#(
    parameter int NODES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // node[3:0], stamp[34:4], leader_node[38:35], leader_stamp[69:39],
    // acks_complete[70], zero fill[71]
    input  logic [S_DATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // granted[0], block_start[4:1], block_index[8:5], member_node[12:9],
    // queue_length[17:13], zero fill[23:18]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

`include "lamport_group_admission_table_defines.svh"

    localparam int IW = ($clog2(NODES) > NODE_W) ? $clog2(NODES) : NODE_W;
    localparam int RW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int SW = ((CW > CFG_W) ? CW : CFG_W) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RING = 3'd1;
    localparam logic [2:0] ST_PICK = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [NODE_W-1:0]  in_node;
    logic [STAMP_W-1:0] in_stamp;
    logic [NODE_W-1:0]  in_lnode;
    logic [STAMP_W-1:0] in_lstamp;
    logic               in_acks;

    logic [2:0]         state_reg;
    logic [RW-1:0]      step_reg;
    logic [CFG_W-1:0]   guides_reg;
    logic [CFG_W-1:0]   group_size_reg;
    logic [CW-1:0]      count_reg;
    logic [OP_W-1:0]    op_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [STAMP_W-1:0] stamp_in_reg;
    logic [NODE_W-1:0]  lnode_reg;
    logic [STAMP_W-1:0] lstamp_reg;
    logic               acks_reg;
    logic [RW-1:0]      pos_reg;
    logic [RW-1:0]      mrank_reg;
    logic               qual_reg;
    logic [SW-1:0]      blk_start_reg;
    logic [CFG_W-1:0]   blk_idx_reg;
    logic [CFG_W-1:0]   k_reg;
    logic               res_grant_reg;
    logic [NODE_W-1:0]  res_member_reg;

    logic                m_valid_reg;
    logic                out_grant_reg;
    logic [NODE_W-1:0]   out_bs_reg;
    logic [NODE_W-1:0]   out_bi_reg;
    logic [NODE_W-1:0]   out_member_reg;
    logic [QLEN_W-1:0]   out_qlen_reg;
    logic                out_last_reg;

    cell_ctl_t          ctl;
    logic               accept;
    logic               is_update;
    logic               out_free;
    logic [CFG_W-1:0]   g_eff;
    logic [NODE_W-1:0]  lead;
    logic [QLEN_W-1:0]  qlen;
    logic [SW-1:0]      emit_pos;
    logic               emit_last;
    logic               qual;

    logic [NODES-1:0]   wr_hit;
    logic [NODES-1:0]   q_hit;
    logic [NODES-1:0]   l_hit;
    logic [NODES-1:0]   act_vec;
    logic               c_act     [NODES];
    logic [STAMP_W-1:0] c_stamp   [NODES];
    logic [RW-1:0]      c_rank    [NODES];
    logic               p_act     [NODES];
    logic [STAMP_W-1:0] p_stamp   [NODES];
    logic [IW-1:0]      p_id      [NODES];

    logic               was_act;
    logic               n_act;
    logic [RW-1:0]      n_rank;
    logic               l_act;
    logic [STAMP_W-1:0] l_stamp;
    logic [RW-1:0]      l_rank;
    logic [NODE_W-1:0]  member_sel;

    assign in_node   = s_tdata[3:0];
    assign in_stamp  = s_tdata[34:4];
    assign in_lnode  = s_tdata[38:35];
    assign in_lstamp = s_tdata[69:39];
    assign in_acks   = s_tdata[70];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_update = (s_tuser == OP_RECORD) || (s_tuser == OP_RELEASE);
    assign out_free  = !m_valid_reg || m_tready;
    assign g_eff     = (group_size_reg == '0) ? CFG_W'(1) : group_size_reg;
    assign lead      = (op_reg == OP_LEADER) ? node_reg : lnode_reg;
    assign emit_pos  = blk_start_reg + SW'(k_reg);
    assign emit_last = ((k_reg + CFG_W'(1)) == g_eff);
    assign qlen      = (SW'(count_reg) > SW'(QLEN_MAX)) ? QLEN_MAX : QLEN_W'(count_reg);

    assign ctl.wr    = accept && is_update;
    assign ctl.set   = (s_tuser == OP_RECORD);
    assign ctl.load  = accept && !is_update;
    assign ctl.shift = (state_reg == ST_RING);
    assign ctl.count = (step_reg != '0);

    for (genvar i = 0; i < NODES; i++) begin : g_cell
        localparam int PREV = (i + NODES - 1) % NODES;

        assign wr_hit[i]  = (IW'(in_node) == IW'(i));
        assign q_hit[i]   = (IW'(node_reg) == IW'(i));
        assign l_hit[i]   = (IW'(lead) == IW'(i));
        assign act_vec[i] = c_act[i];

        lgat_cell #(
            .ID (i),
            .IW (IW),
            .RW (RW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .wr_hit     (wr_hit[i]),
            .wr_stamp   (in_stamp),
            .prev_act   (p_act[PREV]),
            .prev_stamp (p_stamp[PREV]),
            .prev_id    (p_id[PREV]),
            .pass_act   (p_act[i]),
            .pass_stamp (p_stamp[i]),
            .pass_id    (p_id[i]),
            .home_act   (c_act[i]),
            .home_stamp (c_stamp[i]),
            .rank       (c_rank[i])
        );
    end

    always_comb begin
        was_act    = 1'b0;
        n_act      = 1'b0;
        n_rank     = '0;
        l_act      = 1'b0;
        l_stamp    = '0;
        l_rank     = '0;
        member_sel = '0;
        for (int i = 0; i < NODES; i++) begin
            if (wr_hit[i]) begin
                was_act = was_act | c_act[i];
            end
            if (q_hit[i]) begin
                n_act  = n_act | c_act[i];
                n_rank = n_rank | c_rank[i];
            end
            if (l_hit[i]) begin
                l_act   = l_act | c_act[i];
                l_stamp = l_stamp | c_stamp[i];
                l_rank  = l_rank | c_rank[i];
            end
            if (c_act[i] && (SW'(c_rank[i]) == emit_pos)) begin
                member_sel = member_sel | NODE_W'(i);
            end
        end
    end

    assign qual = l_act && (g_eff <= MAX_BLOCK) && (guides_reg != '0) &&
                  ((op_reg == OP_LEADER) ? (acks_reg && (stamp_in_reg == l_stamp))
                                         : (n_act && (lstamp_reg == l_stamp)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guides_reg     <= CFG_W'(1);
            group_size_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GUIDES: guides_reg     <= cfg_data;
                REG_GROUP:  group_size_reg <= cfg_data;
                default:    guides_reg     <= guides_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.wr) begin
            if (ctl.set && !was_act && (wr_hit != '0)) begin
                count_reg <= count_reg + CW'(1);
            end else if (!ctl.set && was_act) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_free && ((state_reg == ST_RESP) || (state_reg == ST_EMIT))) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= is_update ? ST_RESP : ST_RING;
                    end
                end
                ST_RING: begin
                    if (step_reg == RW'(NODES - 1)) begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    state_reg <= ST_SRCH;
                end
                ST_SRCH: begin
                    priority if (!qual_reg) begin
                        state_reg <= ST_RESP;
                    end else if (blk_start_reg == SW'(pos_reg)) begin
                        if ((blk_start_reg + SW'(g_eff) <= SW'(count_reg)) &&
                            (op_reg == OP_LEADER)) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_RESP;
                        end
                    end else if ((blk_start_reg > SW'(pos_reg)) ||
                                 ((blk_idx_reg + CFG_W'(1)) >= guides_reg)) begin
                        state_reg <= ST_RESP;
                    end else begin
                        state_reg <= ST_SRCH;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free && emit_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                step_reg      <= '0;
                res_grant_reg <= 1'b0;
                if (accept) begin
                    op_reg       <= s_tuser;
                    node_reg     <= in_node;
                    stamp_in_reg <= in_stamp;
                    lnode_reg    <= in_lnode;
                    lstamp_reg   <= in_lstamp;
                    acks_reg     <= in_acks;
                end
            end
            ST_RING: begin
                step_reg <= step_reg + RW'(1);
            end
            ST_PICK: begin
                pos_reg       <= l_rank;
                mrank_reg     <= n_rank;
                qual_reg      <= qual;
                blk_start_reg <= '0;
                blk_idx_reg   <= '0;
                k_reg         <= '0;
            end
            ST_SRCH: begin
                res_member_reg <= node_reg;
                if (qual_reg && (blk_start_reg == SW'(pos_reg))) begin
                    res_grant_reg <= (blk_start_reg + SW'(g_eff) <= SW'(count_reg)) &&
                                     (SW'(mrank_reg) >= blk_start_reg) &&
                                     (SW'(mrank_reg) < blk_start_reg + SW'(g_eff));
                end else if (qual_reg && (blk_start_reg < SW'(pos_reg))) begin
                    blk_start_reg <= blk_start_reg + SW'(g_eff);
                    blk_idx_reg   <= blk_idx_reg + CFG_W'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_grant_reg  <= res_grant_reg;
                    out_bs_reg     <= res_grant_reg ? blk_start_reg[NODE_W-1:0] : '0;
                    out_bi_reg     <= res_grant_reg ? blk_idx_reg[NODE_W-1:0] : '0;
                    out_member_reg <= res_grant_reg ? res_member_reg : '0;
                    out_qlen_reg   <= qlen;
                    out_last_reg   <= 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_grant_reg  <= 1'b1;
                    out_bs_reg     <= blk_start_reg[NODE_W-1:0];
                    out_bi_reg     <= blk_idx_reg[NODE_W-1:0];
                    out_member_reg <= member_sel;
                    out_qlen_reg   <= qlen;
                    out_last_reg   <= emit_last;
                    k_reg          <= k_reg + CFG_W'(1);
                end
            end
            default: step_reg <= '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_qlen_reg, out_member_reg, out_bi_reg, out_bs_reg,
                       out_grant_reg};

    `LGAT_ASSERT(a_count_match, aclk, aresetn, $countones(act_vec) == int'(count_reg))
    `LGAT_ASSERT(a_update_reply, aclk, aresetn, accept && is_update |=> state_reg == ST_RESP)
    `LGAT_ASSERT(a_refusal_single, aclk, aresetn, m_tvalid && !m_tdata[0] |-> m_tlast)
    `LGAT_NEVER(a_emit_bound, aclk, aresetn, state_reg == ST_EMIT && k_reg >= g_eff)

endmodule

### tb/lamport_group_admission_table_test.sv
// ----------------------------------------------------------------------------
// Lamport group admission table: self-checking regression
// Drives record, release, leader and membership words through the stream
// port and predicts every output word from a behavioral copy of the request
// slots and the two block registers. Directed words cover the corner cases.
// Random phases under several register settings follow, with bursty stalls
// on both sides (none in the final quiet phase) and one long output stall.
// ----------------------------------------------------------------------------

typedef struct packed {
    bit       granted;
    bit [3:0] block_start;
    bit [3:0] block_index;
    bit [3:0] member_node;
    bit [4:0] queue_length;
    bit       last;
} admission_result_t;

class admission_tracker;
    bit                live   [16];
    bit [30:0]         stamps [16];
    bit [4:0]          block_limit;
    bit [4:0]          block_size;
    admission_result_t pending_results [$];
    int                errors;

    function new();
        for (int i = 0; i < 16; i++) begin
            live[i]   = 1'b0;
            stamps[i] = '0;
        end
        block_limit = 5'd1;
        block_size  = 5'd1;
        errors      = 0;
    endfunction

    function void write_reg(bit [0:0] idx, bit [4:0] value);
        if (idx == lgat_pkg::REG_GUIDES) begin
            block_limit = value;
        end else begin
            block_size = value;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function int span();
        return (block_size == 0) ? 1 : int'(block_size);
    endfunction

    function int active_total();
        int n = 0;
        for (int j = 0; j < 16; j++) begin
            if (live[j]) n++;
        end
        return n;
    endfunction

    // Number of active entries ordered ahead of entry i.
    function int queue_rank(int i);
        int r = 0;
        for (int j = 0; j < 16; j++) begin
            if (live[j] && j != i &&
                (stamps[j] < stamps[i] || (stamps[j] == stamps[i] && j < i))) r++;
        end
        return r;
    endfunction

    function int node_at_rank(int pos);
        for (int j = 0; j < 16; j++) begin
            if (live[j] && queue_rank(j) == pos) return j;
        end
        return 0;
    endfunction

    function bit leader_block(int leader, output int start, output int index);
        int g;
        int pos;
        g     = span();
        pos   = queue_rank(leader);
        start = 0;
        index = 0;
        if (g > 16) return 1'b0;
        if (pos % g != 0) return 1'b0;
        if (pos / g >= int'(block_limit)) return 1'b0;
        if (pos + g - 1 >= active_total()) return 1'b0;
        start = pos;
        index = pos / g;
        return 1'b1;
    endfunction

    function void expect_word(bit granted, int start, int index, int member, bit last);
        admission_result_t r;
        int n;
        n              = active_total();
        r.granted      = granted;
        r.block_start  = 4'(start);
        r.block_index  = 4'(index);
        r.member_node  = 4'(member);
        r.queue_length = (n > 31) ? 5'd31 : 5'(n);
        r.last         = last;
        pending_results.push_back(r);
    endfunction

    function void note_word(bit [1:0] op, bit [3:0] node, bit [30:0] stamp,
                            bit [3:0] lnode, bit [30:0] lstamp, bit acks);
        int start;
        int index;
        int pos;
        bit hit;
        hit = 1'b0;
        case (op)
            lgat_pkg::OP_RECORD: begin
                live[node]   = 1'b1;
                stamps[node] = stamp;
                expect_word(1'b0, 0, 0, 0, 1'b1);
            end
            lgat_pkg::OP_RELEASE: begin
                live[node]   = 1'b0;
                stamps[node] = '0;
                expect_word(1'b0, 0, 0, 0, 1'b1);
            end
            lgat_pkg::OP_LEADER: begin
                if (acks && live[node] && stamps[node] == stamp &&
                    leader_block(node, start, index)) begin
                    for (int k = 0; k < span(); k++) begin
                        expect_word(1'b1, start, index, node_at_rank(start + k),
                                    k == span() - 1);
                    end
                end else begin
                    expect_word(1'b0, 0, 0, 0, 1'b1);
                end
            end
            lgat_pkg::OP_MEMBER: begin
                if (live[node] && live[lnode] && stamps[lnode] == lstamp &&
                    leader_block(lnode, start, index)) begin
                    pos = queue_rank(node);
                    hit = (pos >= start && pos <= start + span() - 1);
                end
                if (hit) begin
                    expect_word(1'b1, start, index, node, 1'b1);
                end else begin
                    expect_word(1'b0, 0, 0, 0, 1'b1);
                end
            end
        endcase
    endfunction

    function void check_word(logic [23:0] data, logic last);
        admission_result_t want;
        if (pending_results.size() == 0) begin
            if (errors < 10) begin
                $display("Unexpected output word: data=%h last=%b", data, last);
            end
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (data[0] !== want.granted || data[4:1] !== want.block_start ||
            data[8:5] !== want.block_index || data[12:9] !== want.member_node ||
            data[17:13] !== want.queue_length || last !== want.last) begin
            if (errors < 10) begin
                $display("Mismatch: expected granted=%0d start=%0d index=%0d member=%0d len=%0d last=%0d",
                         want.granted, want.block_start, want.block_index,
                         want.member_node, want.queue_length, want.last);
                $display("          actual   granted=%0d start=%0d index=%0d member=%0d len=%0d last=%0d",
                         data[0], data[4:1], data[8:5], data[12:9], data[17:13], last);
            end
            errors++;
        end
    endfunction
endclass

module lamport_group_admission_table_test;
    import lgat_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    bit hold_req = 1'b0;
    bit quiet    = 1'b0;

    admission_tracker tracker = new();

    lamport_group_admission_table #(
        .NODES(16)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_word(m_tdata, m_tlast);
        end
    end

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        #(64'd20_000_000);
        $display("lamport_group_admission_table regression: fail");
        $finish;
    end

    task automatic offer_word(input logic [1:0] op, input logic [3:0] node,
                              input logic [30:0] stamp, input logic [3:0] lnode,
                              input logic [30:0] lstamp, input logic acks);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, acks, lstamp, lnode, stamp, node};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_word(op, node, stamp, lnode, lstamp, acks);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [4:0] guides, input logic [4:0] group_size);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GUIDES;
        cfg_data  <= guides;
        @(posedge aclk);
        tracker.write_reg(REG_GUIDES, guides);
        cfg_index <= REG_GROUP;
        cfg_data  <= group_size;
        @(posedge aclk);
        tracker.write_reg(REG_GROUP, group_size);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_word();
        int         total;
        int         g;
        int         top;
        int         head;
        int         pos;
        int         favor;
        int         roll;
        logic [1:0] op;
        logic [3:0] node;
        logic [3:0] lnode;
        logic [30:0] stamp;
        logic [30:0] lstamp;
        logic       acks;
        total  = tracker.active_total();
        g      = tracker.span();
        node   = 4'($urandom_range(0, 15));
        lnode  = 4'($urandom_range(0, 15));
        stamp  = 31'($urandom);
        lstamp = 31'($urandom);
        acks   = ($urandom_range(0, 7) != 0);
        head   = node;
        if (g <= 16 && total >= g) begin
            top = total / g;
            if (top > tracker.block_limit + 1) top = tracker.block_limit + 1;
            head = tracker.node_at_rank(g * $urandom_range(0, top - 1));
        end
        favor = (total < 12) ? 55 : 25;
        roll  = $urandom_range(0, 99);
        if (roll < favor) begin
            op = OP_RECORD;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: stamp = 31'($urandom_range(0, 7));
                4:          stamp = '0;
                5:          stamp = '1;
                default:    ;
            endcase
        end else if (roll < favor + 10) begin
            op = OP_RELEASE;
        end else if ($urandom_range(0, 2) != 0) begin
            op = OP_LEADER;
            if ($urandom_range(0, 5) != 0) node = 4'(head);
            if ($urandom_range(0, 7) != 0) stamp = tracker.stamps[node];
        end else begin
            op = OP_MEMBER;
            if ($urandom_range(0, 5) != 0) lnode = 4'(head);
            if ($urandom_range(0, 7) != 0) lstamp = tracker.stamps[lnode];
            pos = tracker.queue_rank(lnode) + $urandom_range(0, g - 1);
            if ($urandom_range(0, 4) != 0 && pos < total) node = 4'(tracker.node_at_rank(pos));
        end
        offer_word(op, node, stamp, lnode, lstamp, acks);
    endtask

    task automatic run_phase(input logic [4:0] guides, input logic [4:0] group_size,
                             input int count);
        drain();
        set_config(guides, group_size);
        repeat (count) random_word();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_RECORD;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset settings of one block of one entry.
        offer_word(OP_LEADER,  4'd0,  31'h0,        4'd0,  31'h0,        1'b1);
        offer_word(OP_RECORD,  4'd15, 31'h7FFFFFFF, 4'd15, 31'h7FFFFFFF, 1'b1);
        offer_word(OP_RECORD,  4'd0,  31'h0,        4'd0,  31'h0,        1'b0);
        offer_word(OP_RECORD,  4'd5,  31'h0,        4'd0,  31'h0,        1'b0);
        offer_word(OP_LEADER,  4'd0,  31'h0,        4'd15, 31'h7FFFFFFF, 1'b1);
        offer_word(OP_LEADER,  4'd0,  31'h0,        4'd0,  31'h0,        1'b0);
        offer_word(OP_LEADER,  4'd5,  31'h0,        4'd0,  31'h0,        1'b1);
        offer_word(OP_MEMBER,  4'd0,  31'h0,        4'd0,  31'h0,        1'b0);
        offer_word(OP_MEMBER,  4'd5,  31'h0,        4'd0,  31'h0,        1'b1);
        offer_word(OP_RECORD,  4'd0,  31'h7FFFFFFF, 4'd0,  31'h0,        1'b0);
        offer_word(OP_LEADER,  4'd5,  31'h0,        4'd0,  31'h0,        1'b1);
        offer_word(OP_LEADER,  4'd5,  31'h1,        4'd0,  31'h0,        1'b1);
        offer_word(OP_MEMBER,  4'd5,  31'h0,        4'd5,  31'h0,        1'b0);
        offer_word(OP_RELEASE, 4'd9,  31'h0,        4'd0,  31'h0,        1'b0);
        offer_word(OP_RELEASE, 4'd5,  31'h7FFFFFFF, 4'd15, 31'h7FFFFFFF, 1'b1);
        offer_word(OP_LEADER,  4'd0,  31'h7FFFFFFF, 4'd0,  31'h0,        1'b1);
        offer_word(OP_LEADER,  4'd15, 31'h7FFFFFFF, 4'd15, 31'h7FFFFFFF, 1'b1);
        offer_word(OP_MEMBER,  4'd15, 31'h0,        4'd15, 31'h7FFFFFFF, 1'b1);
        offer_word(OP_MEMBER,  4'd0,  31'h0,        4'd0,  31'h7FFFFFFE, 1'b1);
        offer_word(OP_MEMBER,  4'd0,  31'h7FFFFFFF, 4'd0,  31'h7FFFFFFF, 1'b1);
        offer_word(OP_RELEASE, 4'd0,  31'h0,        4'd0,  31'h0,        1'b0);
        offer_word(OP_RELEASE, 4'd15, 31'h0,        4'd0,  31'h0,        1'b0);

        run_phase(5'd2, 5'd4, 30);
        drain();
        set_config(5'd16, 5'd16);
        hold_req = 1'b1;
        repeat (40) random_word();
        run_phase(5'd0,  5'd3,  25);
        run_phase(5'd4,  5'd0,  30);
        run_phase(5'd3,  5'd17, 20);
        run_phase(5'd31, 5'd31, 20);
        run_phase(5'd1,  5'd16, 25);
        run_phase(5'd16, 5'd1,  30);
        run_phase(5'd5,  5'd2,  35);
        run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)), 35);
        drain();
        quiet = 1'b1;
        run_phase(5'd8, 5'd4, 40);

        drain();
        repeat (100) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("lamport_group_admission_table regression: pass");
        end else begin
            $display("lamport_group_admission_table regression: fail");
        end
        $finish;
    end
endmodule
